[hw/rtl/itrd_pkg.sv]
// ----------------------------------------------------------------------------
// itrd_pkg
// Shared types, constants, control store and symbol table for the
// integer-to-radix digit converter.
// ----------------------------------------------------------------------------
package itrd_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int DIV_BITS       = 8;   // quotient bits per divider step
    localparam int RADIX_W        = 7;
    localparam int DIGIT_W        = 6;
    localparam int CHAR_W         = 8;
    localparam int NUMBER_W       = 32;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 7'd2;
    localparam logic [RADIX_W-1:0] RADIX_LIMIT = 7'd65;
    localparam logic [RADIX_W-1:0] RADIX_BIN   = 7'd2;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // program step labels
    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_CHK_BAD = 4'd1;
    localparam step_t STEP_CHK_BIN = 4'd2;
    localparam step_t STEP_DIV     = 4'd3;
    localparam step_t STEP_STORE   = 4'd4;
    localparam step_t STEP_PRIME   = 4'd5;
    localparam step_t STEP_EMIT    = 4'd6;
    localparam step_t STEP_RET     = 4'd7;
    localparam step_t STEP_BIN     = 4'd8;
    localparam step_t STEP_RET_BIN = 4'd9;
    localparam step_t STEP_BAD     = 4'd10;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_DIV_STEP,
        OP_STORE,
        OP_PRIME,
        OP_EMIT,
        OP_OUT_BIN,
        OP_OUT_BAD
    } op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_BAD,
        COND_BIN,
        COND_DIV_MORE,
        COND_QUO_NZ,
        COND_EMIT_MORE,
        COND_BIN_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // control store: jump to target when cond holds, else fall through
    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        unique case (step)
            STEP_IDLE:    w = '{OP_ACCEPT,   COND_ALWAYS,    STEP_CHK_BAD};
            STEP_CHK_BAD: w = '{OP_NOP,      COND_BAD,       STEP_BAD};
            STEP_CHK_BIN: w = '{OP_NOP,      COND_BIN,       STEP_BIN};
            STEP_DIV:     w = '{OP_DIV_STEP, COND_DIV_MORE,  STEP_DIV};
            STEP_STORE:   w = '{OP_STORE,    COND_QUO_NZ,    STEP_DIV};
            STEP_PRIME:   w = '{OP_PRIME,    COND_NEVER,     STEP_IDLE};
            STEP_EMIT:    w = '{OP_EMIT,     COND_EMIT_MORE, STEP_EMIT};
            STEP_RET:     w = '{OP_NOP,      COND_ALWAYS,    STEP_IDLE};
            STEP_BIN:     w = '{OP_OUT_BIN,  COND_BIN_MORE,  STEP_BIN};
            STEP_RET_BIN: w = '{OP_NOP,      COND_ALWAYS,    STEP_IDLE};
            STEP_BAD:     w = '{OP_OUT_BAD,  COND_ALWAYS,    STEP_IDLE};
            default:      w = '{OP_NOP,      COND_ALWAYS,    STEP_IDLE};
        endcase
        return w;
    endfunction

    // 0-9, A-Z, a-z, '+', '/'
    function automatic logic [CHAR_W-1:0] sym_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 6'd10)
            c = 8'h30 + CHAR_W'(d);
        else if (d < 6'd36)
            c = 8'h41 + CHAR_W'(d - 6'd10);
        else if (d < 6'd62)
            c = 8'h61 + CHAR_W'(d - 6'd36);
        else if (d == 6'd62)
            c = 8'h2B;
        else
            c = 8'h2F;
        return c;
    endfunction

endpackage

[hw/rtl/integer_to_radix_digits_top.sv]
// ----------------------------------------------------------------------------
// integer_to_radix_digits_top
// Converts an unsigned value to its digits in a base from 2 to 64, most
// significant digit first, one output item per digit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one item = number (s_tdata[31:0]) and radix (s_tdata[38:32]).
//   m_* channel: one item per digit; tdata = digit value and ASCII symbol,
//   tlast on the final digit, tuser = bad radix flag (single item, digit 0).
//   Base 2 gives VALUE_BITS digits with leading zeros; other bases give the
//   fewest digits (zero gives "0").
// Timing:
//   One item is converted at a time; s_tready is high only in the idle step.
//   Each digit of base b takes D = ceil(VALUE_BITS/8) divider steps (8
//   quotient bits per cycle through a single shared restoring divider).
//   Digits are sent one per cycle while the receiver takes them.
// Reset:
//   rst_n clears the step counter, the digit count and the output valid.
// Stall:
//   When m_tready is low while an item is held, the output register holds and
//   the sequencer waits on its emit, binary or bad radix output step; no digit is lost or repeated.
// ----------------------------------------------------------------------------
module integer_to_radix_digits_top #(
    parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] number, [38:32] radix, [39] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [5:0] digit_value, [13:6] digit_char, [15:14] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] bad_radix
);
    import itrd_pkg::*;

    localparam int DIV_ITERS = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W     = DIV_ITERS * DIV_BITS;
    localparam int ITER_W    = (DIV_ITERS > 1) ? $clog2(DIV_ITERS) : 1;
    localparam int CNT_W     = $clog2(VALUE_BITS + 1);
    localparam int ADDR_W    = $clog2(VALUE_BITS);

    // sequencer
    step_t  upc_reg, upc_next;
    ucode_t uw;
    logic   stall;
    logic   cond_true;

    // datapath
    logic [DIV_W-1:0]   div_reg;
    logic [DIGIT_W-1:0] rem_reg;
    logic [RADIX_W-1:0] radix_reg;
    logic [ITER_W-1:0]  iter_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [ADDR_W-1:0]  ptr_reg;
    logic [DIGIT_W-1:0] rd_reg;
    logic [DIGIT_W-1:0] store_mem [VALUE_BITS];

    logic               out_valid_reg;
    logic [DIGIT_W-1:0] out_digit_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_last_reg;
    logic               out_bad_reg;

    logic               out_free;
    logic               out_load;
    logic               fire;
    logic [DIV_W-1:0]   num_ext;
    logic [DIV_W-1:0]   num_masked;
    logic [DIV_BITS-1:0] quo_byte;
    logic [DIGIT_W-1:0] rem_div;
    logic [CNT_W-1:0]   cnt_dec;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;
    logic               radix_bad;

    assign uw        = ucode_rom(upc_reg);
    assign out_free  = !out_valid_reg || m_tready;
    assign cnt_dec   = count_reg - CNT_W'(1);
    assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg >= RADIX_LIMIT);

    assign s_tready = (uw.op == OP_ACCEPT);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_char_reg, out_digit_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

    // bits of number above VALUE_BITS are dropped
    assign num_ext = DIV_W'(s_tdata[NUMBER_W-1:0]);
    always_comb
    begin
        for (int i = 0; i < DIV_W; i++)
        begin
            num_masked[i] = (i < VALUE_BITS) ? num_ext[i] : 1'b0;
        end
    end

    // one divider step: DIV_BITS restoring iterations on a 7-bit remainder
    always_comb
    begin
        logic [RADIX_W-1:0]  r;
        logic [DIV_BITS-1:0] b;
        r = {1'b0, rem_reg};
        b = div_reg[DIV_W-1 -: DIV_BITS];
        quo_byte = '0;
        for (int i = DIV_BITS - 1; i >= 0; i--)
        begin
            r = {r[RADIX_W-2:0], b[i]};
            if (r >= radix_reg)
            begin
                r = r - radix_reg;
                quo_byte[i] = 1'b1;
            end
        end
        rem_div = r[DIGIT_W-1:0];
    end

    always_comb
    begin
        unique case (uw.op)
            OP_ACCEPT:                       stall = !s_tvalid;
            OP_EMIT, OP_OUT_BIN, OP_OUT_BAD: stall = !out_free;
            default:                         stall = 1'b0;
        endcase
    end

    assign fire     = !stall;
    assign out_load = fire && ((uw.op == OP_EMIT) || (uw.op == OP_OUT_BIN) ||
                               (uw.op == OP_OUT_BAD));

    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_BAD:       cond_true = radix_bad;
            COND_BIN:       cond_true = (radix_reg == RADIX_BIN);
            COND_DIV_MORE:  cond_true = (iter_reg != ITER_W'(DIV_ITERS - 1));
            COND_QUO_NZ:    cond_true = (div_reg != '0);
            COND_EMIT_MORE: cond_true = (count_reg != CNT_W'(1));
            COND_BIN_MORE:  cond_true = (count_reg != CNT_W'(VALUE_BITS - 1));
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
            upc_next = upc_reg;
        else if (cond_true)
            upc_next = uw.target;
        else
            upc_next = upc_reg + step_t'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (fire)
            begin
                unique case (uw.op)
                    OP_ACCEPT:  count_reg <= '0;
                    OP_STORE:   count_reg <= count_reg + CNT_W'(1);
                    OP_EMIT:    count_reg <= cnt_dec;
                    OP_OUT_BIN: count_reg <= count_reg + CNT_W'(1);
                    default:    count_reg <= count_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            unique case (uw.op)
                OP_ACCEPT:
                begin
                    div_reg   <= num_masked;
                    radix_reg <= s_tdata[NUMBER_W +: RADIX_W];
                    rem_reg   <= '0;
                    iter_reg  <= '0;
                end
                OP_DIV_STEP:
                begin
                    // quotient byte enters at the bottom as the dividend shifts up
                    div_reg  <= DIV_W'({div_reg, quo_byte});
                    rem_reg  <= rem_div;
                    iter_reg <= iter_reg + ITER_W'(1);
                end
                OP_STORE:
                begin
                    rem_reg  <= '0;
                    iter_reg <= '0;
                end
                OP_PRIME:
                begin
                    ptr_reg <= cnt_dec[ADDR_W-1:0] - ADDR_W'(1);
                end
                OP_EMIT:
                begin
                    out_digit_reg <= rd_reg;
                    out_char_reg  <= sym_char(rd_reg);
                    out_last_reg  <= (count_reg == CNT_W'(1));
                    out_bad_reg   <= 1'b0;
                    ptr_reg       <= ptr_reg - ADDR_W'(1);
                end
                OP_OUT_BIN:
                begin
                    out_digit_reg <= DIGIT_W'(div_reg[VALUE_BITS-1]);
                    out_char_reg  <= sym_char(DIGIT_W'(div_reg[VALUE_BITS-1]));
                    out_last_reg  <= (count_reg == CNT_W'(VALUE_BITS - 1));
                    out_bad_reg   <= 1'b0;
                    div_reg       <= {div_reg[DIV_W-2:0], 1'b0};
                end
                OP_OUT_BAD:
                begin
                    out_digit_reg <= '0;
                    out_char_reg  <= '0;
                    out_last_reg  <= 1'b1;
                    out_bad_reg   <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // digit store: written least significant first, read back in reverse
    assign rd_addr = (uw.op == OP_PRIME) ? cnt_dec[ADDR_W-1:0] : ptr_reg;
    assign rd_en   = (uw.op == OP_PRIME) || ((uw.op == OP_EMIT) && fire);

    always_ff @(posedge clk)
    begin
        if (uw.op == OP_STORE)
            store_mem[count_reg[ADDR_W-1:0]] <= rem_reg;
        if (rd_en)
            rd_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    a_accept_then_check: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (upc_reg == STEP_CHK_BAD))
        else $error("accept not followed by radix check");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == STEP_DIV) |-> ({1'b0, rem_reg} < radix_reg))
        else $error("remainder not below radix");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(VALUE_BITS))
        else $error("digit count out of range");

    a_bad_item_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("bad radix item malformed");

endmodule

[sim/tb_integer_to_radix_digits_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_radix_digits_top
// Self-checking bench for the radix digit converter. Items go in on the slave
// stream. Every accepted item is converted here as well: the number is divided
// by its base, or its bits are listed for base 2, and the expected digits are
// queued. Each digit that comes out of the master stream is checked against
// the oldest queued digit. Both sides insert random gaps. One phase holds the
// receiver off for a long time so that the converter stalls its input.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_digits_top;
    import itrd_pkg::*;

    localparam int    NUM_RANDOM    = 75;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    IDLE_LIMIT    = 5000;
    localparam int    DRAIN_CYCLES  = 60;
    localparam string ALPHABET      =
        "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz+/";

    typedef struct {
        logic [DIGIT_W-1:0] digit_value;
        logic [CHAR_W-1:0]  digit_char;
        logic               is_last;
        logic               bad_radix;
    } digit_item_t;

    logic        clk      = 1'b0;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] number, [38:32] radix, [39] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [5:0] digit_value, [13:6] digit_char, [15:14] zero
    logic        m_tlast;
    logic        m_tuser;         // [0] bad_radix

    digit_item_t pending_digits[$];
    int          error_count   = 0;
    int          idle_cycles   = 0;
    int          send_max_gap  = 12;
    int          recv_max_gap  = 12;
    bit          hold_request  = 1'b0;

    integer_to_radix_digits_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Expected digits of one item, most significant first
    function automatic void convert_to_digits(input logic [NUMBER_W-1:0] number,
                                              input logic [RADIX_W-1:0] radix);
        digit_item_t        item;
        logic [DIGIT_W-1:0] lsb_first[NUMBER_W];
        logic [NUMBER_W-1:0] rest;
        int                 count;
        int                 k;
        if (radix < RADIX_MIN || radix >= RADIX_LIMIT)
        begin
            item.digit_value = '0;
            item.digit_char  = '0;
            item.is_last     = 1'b1;
            item.bad_radix   = 1'b1;
            pending_digits.push_back(item);
            return;
        end
        count = 0;
        if (radix == RADIX_BIN)
        begin
            for (k = 0; k < NUMBER_W; k++)
                lsb_first[k] = DIGIT_W'(number[k]);
            count = NUMBER_W;
        end
        else
        begin
            rest = number;
            do
            begin
                lsb_first[count] = DIGIT_W'(rest % NUMBER_W'(radix));
                count++;
                rest = rest / NUMBER_W'(radix);
            end
            while (rest != 0);
        end
        for (k = count - 1; k >= 0; k--)
        begin
            item.digit_value = lsb_first[k];
            item.digit_char  = ALPHABET[lsb_first[k]];
            item.is_last     = (k == 0);
            item.bad_radix   = 1'b0;
            pending_digits.push_back(item);
        end
    endfunction

    task automatic send_item(input logic [NUMBER_W-1:0] number,
                             input logic [RADIX_W-1:0] radix);
        int gap;
        gap = $urandom_range(0, send_max_gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, radix, number};
        do @(posedge clk); while (!s_tready);
        convert_to_digits(number, radix);
    endtask

    task automatic test_binary_extremes();
        send_item(32'h0000_0000, RADIX_BIN);
        send_item(32'hFFFF_FFFF, RADIX_BIN);
        send_item(32'h8000_0001, RADIX_BIN);
        send_item(32'h5A5A_A5A5, RADIX_BIN);
    endtask

    task automatic test_bad_radix();
        send_item(32'hFFFF_FFFF, 7'd0);
        send_item(32'h1234_5678, 7'd1);
        send_item(32'h0000_0000, RADIX_LIMIT);
        send_item(32'hFFFF_FFFF, 7'd127);
        send_item(32'h0000_0007, 7'd100);
    endtask

    task automatic test_valid_edges();
        send_item(32'h0000_0000, 7'd10);
        send_item(32'h0000_0000, 7'd64);
        send_item(32'hFFFF_FFFF, 7'd3);      // longest division chain
        send_item(32'hFFFF_FFFF, 7'd64);
        send_item(32'h0000_003F, 7'd64);     // top symbol
        send_item(32'h0000_003E, 7'd64);
        send_item(32'h0000_0040, 7'd64);
        send_item(32'h0000_0023, 7'd36);
        send_item(32'h0000_0024, 7'd36);
        send_item(32'hFFFF_FFFF, 7'd16);
        send_item(32'd12345,     7'd10);
        send_item(32'hFFFF_FFFF, 7'd63);
        send_item(32'h0000_0001, 7'd5);
        send_item(32'd4294967295, 7'd10);
    endtask

    task automatic test_random_items();
        logic [RADIX_W-1:0]  radix;
        logic [NUMBER_W-1:0] number;
        int                  pick;
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            // alternate between random gaps and full-rate stretches
            case ((i / 20) % 4)
                0: begin send_max_gap = 12; recv_max_gap = 12; end
                1: begin send_max_gap = 0;  recv_max_gap = 0;  end
                2: begin send_max_gap = 12; recv_max_gap = 0;  end
                default: begin send_max_gap = 0; recv_max_gap = 12; end
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 12)
                radix = $urandom_range(0, 1) ? RADIX_W'($urandom_range(0, 1))
                                             : RADIX_W'($urandom_range(65, 127));
            else if (pick < 22)
                radix = RADIX_BIN;
            else if (pick < 30)
                radix = 7'd64;
            else
                radix = RADIX_W'($urandom_range(3, 63));
            case ($urandom_range(0, 3))
                0: number = $urandom;
                1: number = $urandom >> $urandom_range(0, 31);
                2: number = $urandom_range(0, 200);
                default: number = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            endcase
            send_item(number, radix);
        end
        send_max_gap = 12;
        recv_max_gap = 12;
    endtask

    // Receiver stops for a long stretch while items keep coming
    task automatic test_output_backpressure();
        send_max_gap = 0;
        hold_request = 1'b1;
        send_item(32'hFFFF_FFFF, 7'd3);
        send_item(32'hDEAD_BEEF, RADIX_BIN);
        send_item(32'h0000_0000, 7'd0);
        send_item(32'h7FFF_FFFF, 7'd7);
        send_item(32'h0000_0000, 7'd9);
        send_item(32'hCAFE_F00D, 7'd64);
        send_max_gap = 12;
    endtask

    // Output ready, one draw per item
    initial
    begin : receiver
        int wait_cycles;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_request)
            begin
                wait_cycles  = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else
                wait_cycles = $urandom_range(0, recv_max_gap);
            if (wait_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    always @(posedge clk)
    begin
        digit_item_t exp_item;
        if (m_tvalid && m_tready)
        begin
            if (pending_digits.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected digit, actual value %0d char %h last %b bad %b",
                         $time, m_tdata[5:0], m_tdata[13:6], m_tlast, m_tuser);
            end
            else
            begin
                exp_item = pending_digits.pop_front();
                if (m_tdata[5:0] !== exp_item.digit_value || m_tdata[13:6] !== exp_item.digit_char
                    || m_tlast !== exp_item.is_last || m_tuser !== exp_item.bad_radix)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected value %0d char %h last %b bad %b, actual value %0d char %h last %b bad %b",
                             $time, exp_item.digit_value, exp_item.digit_char,
                             exp_item.is_last, exp_item.bad_radix,
                             m_tdata[5:0], m_tdata[13:6], m_tlast, m_tuser);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= IDLE_LIMIT)
        begin
            $display("tb_integer_to_radix_digits_top NOT OK");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        // driven at time 0 so the asynchronous reset sees a falling edge
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_binary_extremes();
        test_bad_radix();
        test_valid_edges();
        test_random_items();
        test_output_backpressure();
        s_tvalid <= 1'b0;
        while (pending_digits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_integer_to_radix_digits_top OK");
        else
            $display("tb_integer_to_radix_digits_top NOT OK");
        $finish;
    end

endmodule
